@@ rtl/sfcr_pkg.sv @@
// Package for the SLIP frame receiver with CRC-16/ARC check.
// Holds the framing codes, register indexes, result struct and CRC step.
// Depends on nothing.
package sfcr_pkg;

  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] MAX_FRAME_RESET = 8'd131;
  localparam logic [7:0] MIN_FRAME_RESET = 8'd4;

  typedef enum logic {
    REG_MAX_FRAME = 1'b0,
    REG_MIN_FRAME = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       valid;
    logic       is_frame_end;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic       frame_good;
  } sfcr_result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/sfcr_decoder.sv @@
// Frame state of the SLIP receiver: escape flag, byte count and CRCs.
// Decodes one raw byte per step and forms its result combinationally.
// Depends on sfcr_pkg.
module sfcr_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            max_frame_bytes,
  input  logic [7:0]            min_frame_bytes,
  output sfcr_pkg::sfcr_result_t result
);
  import sfcr_pkg::*;

  logic        escape_pending, escape_pending_next;
  logic [7:0]  stored_count, stored_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  decoded;

  always_comb begin
    escape_pending_next = escape_pending;
    stored_count_next   = stored_count;
    running_crc_next    = running_crc;
    received_crc_next   = received_crc;
    result              = '0;
    decoded             = rx_byte;
    if (escape_pending && rx_byte == CODE_ESC_END) begin
      decoded = CODE_END;
    end else if (escape_pending && rx_byte == CODE_ESC_ESC) begin
      decoded = CODE_ESC;
    end
    if (rx_byte == CODE_END) begin
      if (stored_count != 8'd0) begin
        result.valid        = 1'b1;
        result.is_frame_end = 1'b1;
        result.frame_length = stored_count;
        result.frame_good   = (stored_count >= min_frame_bytes) && (stored_count >= 8'd2) &&
                              (running_crc == received_crc);
        escape_pending_next = 1'b0;
        stored_count_next   = 8'd0;
        running_crc_next    = 16'd0;
        received_crc_next   = 16'd0;
      end
    end else if (rx_byte == CODE_ESC) begin
      escape_pending_next = 1'b1;
    end else begin
      escape_pending_next = 1'b0;
      if (stored_count < max_frame_bytes) begin
        if (stored_count == 8'd0) begin
          received_crc_next = {received_crc[15:8], decoded};
          running_crc_next  = crc_feed(running_crc, 8'd0);
        end else if (stored_count == 8'd1) begin
          received_crc_next = {decoded, received_crc[7:0]};
          running_crc_next  = crc_feed(running_crc, 8'd0);
        end else begin
          running_crc_next  = crc_feed(running_crc, decoded);
        end
        result.valid      = 1'b1;
        result.byte_value = decoded;
        result.byte_index = stored_count;
        stored_count_next = stored_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      stored_count   <= 8'd0;
      running_crc    <= 16'd0;
      received_crc   <= 16'd0;
    end else if (step) begin
      escape_pending <= escape_pending_next;
      stored_count   <= stored_count_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
    end
  end

endmodule

@@ rtl/slip_frame_crc_receiver.sv @@
// Top level of the SLIP frame receiver with CRC-16/ARC frame check.
// Input register, frame decoder and output register; uses sfcr_pkg, sfcr_decoder.
//
//   Channel  Direction  Beat
//   in       sink       rx_byte
//   out      source     is_frame_end, byte_value, byte_index, frame_length, frame_good
//   cfg      sink       cfg_index, cfg_data
//
// One raw byte per cycle is taken unless the output stalls; its result is registered.
// The combinational decode from input register to output register sets the rate.
// Reset clears the frame state and both beat valid flags and restores the limits.
// A stalled result holds the output; one more byte waits in the input register.
module slip_frame_crc_receiver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      is_frame_end,
  output logic [7:0]                byte_value,
  output logic [7:0]                byte_index,
  output logic [7:0]                frame_length,
  output logic                      frame_good,
  input  logic                      cfg_write,
  input  sfcr_pkg::reg_index_t      cfg_index,
  input  logic [7:0]                cfg_data
);
  import sfcr_pkg::*;

  logic         in_full;
  logic [7:0]   in_byte;
  logic [7:0]   max_frame_bytes;
  logic [7:0]   min_frame_bytes;
  logic         advance;
  logic         step;
  sfcr_result_t result;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = in_full && !advance;
  assign step     = in_full && advance;

  sfcr_decoder u_decoder (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .rx_byte         (in_byte),
    .max_frame_bytes (max_frame_bytes),
    .min_frame_bytes (min_frame_bytes),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
      min_frame_bytes <= MIN_FRAME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_FRAME: max_frame_bytes <= cfg_data;
        REG_MIN_FRAME: min_frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= step && result.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
    if (advance && step && result.valid) begin
      is_frame_end <= result.is_frame_end;
      byte_value   <= result.byte_value;
      byte_index   <= result.byte_index;
      frame_length <= result.frame_length;
      frame_good   <= result.frame_good;
    end
  end

endmodule

@@ rtl/sfcr_checker.sv @@
// Port-level checks for the SLIP frame receiver, bound to its top level.
// Depends on sfcr_pkg and slip_frame_crc_receiver.
module sfcr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [7:0]           rx_byte,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 is_frame_end,
  input logic [7:0]           byte_value,
  input logic [7:0]           byte_index,
  input logic [7:0]           frame_length,
  input logic                 frame_good,
  input logic                 cfg_write,
  input sfcr_pkg::reg_index_t cfg_index,
  input logic [7:0]           cfg_data
);
  import sfcr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_value) && $stable(frame_length))
    else $error("Stalled result beat changed.");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_frame_end |-> byte_value == 8'd0 && byte_index == 8'd0 &&
    frame_length != 8'd0)
    else $error("Frame end beat carries byte fields.");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_frame_end |-> frame_length == 8'd0 && !frame_good)
    else $error("Payload beat carries frame end fields.");

  a_short_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_frame_end && frame_length < 8'd2 |-> !frame_good)
    else $error("Frame shorter than its CRC reported good.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Pipeline not empty after reset.");

endmodule

bind slip_frame_crc_receiver sfcr_checker u_sfcr_checker (.*);

@@ bench/testbench.sv @@
// Self-checking bench for slip_frame_crc_receiver: SLIP frames, escapes and CRC-16/ARC checks.
// A scoreboard class predicts every result beat; plain tasks drive bytes and limit writes.
// Depends on sfcr_pkg and the slip_frame_crc_receiver RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcr_pkg::*;

  typedef struct packed {
    logic       is_end;
    logic [7:0] value;
    logic [7:0] index;
    logic [7:0] length;
    logic       good;
  } frame_beat_t;

  class deframe_scoreboard;
    logic [7:0]  max_len;
    logic [7:0]  min_len;
    logic        esc_pending;
    logic [7:0]  count;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    frame_beat_t expected[$];
    int          errors;
    int          byte_beats;
    int          frame_reports;
    int          good_frames;

    function new();
      max_len = MAX_FRAME_RESET;
      min_len = MIN_FRAME_RESET;
      errors = 0;
      byte_beats = 0;
      frame_reports = 0;
      good_frames = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      esc_pending = 1'b0;
      count = 8'd0;
      crc = 16'd0;
      rx_crc = 16'd0;
    endfunction

    function logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = acc[0] ^ d[i];
        acc = acc >> 1;
        if (fb) begin
          acc = acc ^ CRC_POLY;
        end
      end
      return acc;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void note_byte(logic [7:0] raw);
      logic [7:0]  c;
      frame_beat_t b;
      c = raw;
      b = '0;
      if (raw == CODE_END) begin
        if (count == 8'd0) begin
          return;
        end
        b.is_end = 1'b1;
        b.length = count;
        b.good = (count >= min_len) && (count >= 8'd2) && (crc == rx_crc);
        expected.push_back(b);
        clear_frame();
        return;
      end
      if (raw == CODE_ESC) begin
        esc_pending = 1'b1;
        return;
      end
      if (esc_pending) begin
        if (raw == CODE_ESC_END) begin
          c = CODE_END;
        end else if (raw == CODE_ESC_ESC) begin
          c = CODE_ESC;
        end
        esc_pending = 1'b0;
      end
      if (count >= max_len) begin
        return;
      end
      if (count == 8'd0) begin
        rx_crc[7:0] = c;
        crc = crc_byte(crc, 8'd0);
      end else if (count == 8'd1) begin
        rx_crc[15:8] = c;
        crc = crc_byte(crc, 8'd0);
      end else begin
        crc = crc_byte(crc, c);
      end
      b.value = c;
      b.index = count;
      expected.push_back(b);
      count = count + 8'd1;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t want;
      if (expected.size() == 0) begin
        $error("Result beat with nothing expected: end=%0d value=%0d", got.is_end, got.value);
        errors++;
        return;
      end
      want = expected.pop_front();
      check_field("is_frame_end", {7'd0, want.is_end}, {7'd0, got.is_end});
      check_field("byte_value", want.value, got.value);
      check_field("byte_index", want.index, got.index);
      check_field("frame_length", want.length, got.length);
      check_field("frame_good", {7'd0, want.good}, {7'd0, got.good});
      if (want.is_end) begin
        frame_reports++;
        if (want.good) begin
          good_frames++;
        end
      end else begin
        byte_beats++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       is_frame_end;
  logic [7:0] byte_value;
  logic [7:0] byte_index;
  logic [7:0] frame_length;
  logic       frame_good;
  logic       cfg_write;
  reg_index_t cfg_index;
  logic [7:0] cfg_data;

  deframe_scoreboard sb;
  logic [7:0] cfg_max;
  int         gap_pct;
  int         stall_pct;
  int         hold_len;
  int         raw_count;
  int         settings;
  bit         clean;

  slip_frame_crc_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_frame_end (is_frame_end),
    .byte_value   (byte_value),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .frame_good   (frame_good),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver stalls at random, or stalls without a break while hold_len is set.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        for (int i = 1; i < hold_len; i++) @(posedge clk);
        hold_len = 0;
      end else begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    frame_beat_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_byte(rx_byte);
      end
      if (out_valid && !out_stall) begin
        got.is_end = is_frame_end;
        got.value = byte_value;
        got.index = byte_index;
        got.length = frame_length;
        got.good = frame_good;
        sb.check_beat(got);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0: return CODE_END;
      1: return CODE_ESC;
      2: return CODE_ESC_END;
      3: return CODE_ESC_ESC;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_raw(input logic [7:0] b);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    raw_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] max_bytes, input logic [7:0] min_bytes);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_FRAME;
    cfg_data <= max_bytes;
    @(posedge clk);
    cfg_index <= REG_MIN_FRAME;
    cfg_data <= min_bytes;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.max_len = max_bytes;
    sb.min_len = min_bytes;
    cfg_max = max_bytes;
    settings++;
  endtask

  // A frame is built so that its stored part carries a matching CRC when asked.
  task automatic send_frame(input int len, input bit make_good, input bit corrupt);
    logic [7:0]  payload[];
    logic [15:0] sum;
    int          stored;
    if (!clean) begin
      send_raw(8'h00);
      send_raw(CODE_END);
    end
    payload = new[len];
    foreach (payload[i]) payload[i] = pick_byte();
    stored = (len < int'(cfg_max)) ? len : int'(cfg_max);
    if (make_good && stored >= 2) begin
      sum = 16'd0;
      for (int i = 2; i < stored; i++) sum = sb.crc_byte(sum, payload[i]);
      payload[0] = sum[7:0];
      payload[1] = sum[15:8];
    end
    if (corrupt && stored > 0) begin
      payload[$urandom_range(stored - 1)] ^= 8'h01 << $urandom_range(7);
    end
    foreach (payload[i]) begin
      if (payload[i] == CODE_END) begin
        send_raw(CODE_ESC);
        send_raw(CODE_ESC_END);
      end else if (payload[i] == CODE_ESC) begin
        send_raw(CODE_ESC);
        send_raw(CODE_ESC_ESC);
      end else begin
        if (payload[i] != CODE_ESC_END && payload[i] != CODE_ESC_ESC &&
            $urandom_range(15) == 0) begin
          send_raw(CODE_ESC);
        end
        send_raw(payload[i]);
      end
    end
    send_raw(CODE_END);
    clean = 1'b1;
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_raw(pick_byte());
    clean = 1'b0;
  endtask

  task automatic run_random(input int target);
    int stop;
    int len;
    stop = raw_count + target;
    while (raw_count < stop) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(9) == 0) begin
          len = ((cfg_max > 8'd2) ? int'(cfg_max) - 2 : 0) + $urandom_range(5);
        end else begin
          len = $urandom_range(12);
        end
        send_frame(len, $urandom_range(9) < 7, $urandom_range(9) == 0);
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'd0;
    cfg_write = 1'b0;
    cfg_index = REG_MAX_FRAME;
    cfg_data = 8'd0;
    cfg_max = MAX_FRAME_RESET;
    gap_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    raw_count = 0;
    settings = 0;
    clean = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty frame, escape held over an empty frame, double escape, plain escaped
    // byte, and an end marker right after an escape.
    send_raw(CODE_END);
    send_raw(CODE_ESC);
    send_raw(CODE_END);
    send_raw(CODE_ESC_END);
    send_raw(CODE_ESC);
    send_raw(CODE_ESC);
    send_raw(CODE_ESC_ESC);
    send_raw(8'h00);
    send_raw(8'hFF);
    send_raw(CODE_ESC);
    send_raw(8'h41);
    send_raw(CODE_ESC);
    send_raw(CODE_END);
    send_frame(2, 1'b1, 1'b0);
    send_frame(4, 1'b1, 1'b0);
    send_frame(5, 1'b1, 1'b1);

    set_limits(8'd255, 8'd255);
    send_frame(258, 1'b1, 1'b0);
    send_frame(255, 1'b1, 1'b0);

    set_limits(8'd0, 8'd0);
    run_random(40);
    set_limits(8'd1, 8'd1);
    run_random(40);
    set_limits(8'd2, 8'd2);
    run_random(80);

    set_limits(MAX_FRAME_RESET, MIN_FRAME_RESET);
    run_random(100);

    gap_pct = 48;
    set_limits(8'($urandom_range(2, 40)), 8'($urandom_range(0, 30)));
    run_random(100);

    gap_pct = 0;
    stall_pct = 48;
    set_limits(8'($urandom_range(2, 40)), 8'($urandom_range(0, 30)));
    hold_len = 80;
    send_frame(40, 1'b1, 1'b0);
    run_random(100);

    gap_pct = 26;
    stall_pct = 26;
    set_limits(8'($urandom_range(2, 40)), 8'($urandom_range(0, 30)));
    run_random(100);

    settle();
    $display("Sent %0d raw bytes under %0d limit settings (caps 0 to 255) with gaps and stalls.",
             raw_count, settings);
    $display("Checked %0d decoded byte beats and %0d frame reports, %0d of them good.",
             sb.byte_beats, sb.frame_reports, sb.good_frames);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
